>>> src/mab_pkg.sv
// Shared types, constants and codes for the multi-arena bump allocator.
package mab_pkg;

    // Default geometry of the pool.
    localparam int NUM_ARENAS_DEF = 8;
    localparam int ARENA_SIZE_DEF = 4096;

    // Fixed field widths of the transactions.
    localparam int SIZE_W = 13;
    localparam int LG_W   = 4;
    localparam int ADDR_W = 15;
    localparam int LIVE_W = 13;

    // Packed stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // An arena whose live count has reached this value takes no more objects.
    localparam logic [LIVE_W-1:0] LIVE_MAX = 13'h1FFF;

    // Request kinds carried in the slave-side tuser.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_PUSH
    } seq_state_t;

endpackage

>>> src/mab_arena_ram.sv
// Per-arena state memory: one write port and one registered read port.
module mab_arena_ram
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 26
)
(
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mab_seq.sv
// Sequencer: first-fit scan, arena opening and free handling over the arena memory.
module mab_seq
    import mab_pkg::*;
#(
    parameter int NUM_ARENAS = NUM_ARENAS_DEF,
    parameter int ARENA_SIZE = ARENA_SIZE_DEF,
    parameter int AW         = (NUM_ARENAS > 1) ? $clog2(NUM_ARENAS) : 1,
    parameter int FW         = $clog2(ARENA_SIZE + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [SIZE_W-1:0]    in_size,
    input  logic [LG_W-1:0]      in_lg,
    input  logic [ADDR_W-1:0]    in_faddr,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res,
    output logic [AW-1:0]        mem_rd_addr,
    input  logic [FW+LIVE_W-1:0] mem_rd_data,
    output logic                 mem_wr_en,
    output logic [AW-1:0]        mem_wr_addr,
    output logic [FW+LIVE_W-1:0] mem_wr_data
);

    localparam int CW = $clog2(NUM_ARENAS + 1);
    localparam int SW = ((FW > ADDR_W) ? FW : ADDR_W) + 2;
    // Arena index of a free address by reciprocal multiplication, exact for 15-bit addresses.
    localparam int DL = $clog2(ARENA_SIZE);
    localparam int SH = ADDR_W + DL;
    localparam int MW = 17;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(ARENA_SIZE) - 64'd1) / 64'(ARENA_SIZE);
    localparam int PW = ADDR_W + MW;

    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       opened_reg, opened_next;
    logic [AW-1:0]       k_reg, k_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   q_reg, q_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [LG_W-1:0]     lg_reg, lg_next;
    res_t                res_reg, res_next;

    logic [FW-1:0]       fill_d;
    logic [LIVE_W-1:0]   live_d;
    logic [SW-1:0]       fill_ext, mask, pad, start, need;
    logic                fits, last_arena, q_in_range, too_big;
    logic [PW-1:0]       quot_prod;
    logic [FW-1:0]       wr_fill;
    logic [LIVE_W-1:0]   wr_live;

    assign fill_d = mem_rd_data[FW+LIVE_W-1:LIVE_W];
    assign live_d = mem_rd_data[LIVE_W-1:0];

    // Pad the fill level up to the alignment and check the fit.
    assign fill_ext = SW'(fill_d);
    assign mask     = (SW'(1) << lg_reg) - SW'(1);
    assign pad      = (~fill_ext + SW'(1)) & mask;
    assign start    = fill_ext + pad;
    assign need     = start + SW'(size_reg);
    assign fits     = (live_d != LIVE_MAX) && (need <= SW'(ARENA_SIZE));

    assign last_arena = (CW'(k_reg) + CW'(1)) == opened_reg;
    assign too_big    = SW'(in_size) > SW'(ARENA_SIZE);
    assign quot_prod  = PW'(in_faddr) * PW'(RECIP[MW-1:0]);
    assign q_in_range = q_reg < ADDR_W'(opened_reg);

    assign mem_wr_data = {wr_fill, wr_live};
    assign res         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            opened_reg <= '0;
            res_reg    <= '{block_address: '0, status: ST_OK};
        end
        else
        begin
            state_reg  <= state_next;
            opened_reg <= opened_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        base_reg <= base_next;
        q_reg    <= q_next;
        size_reg <= size_next;
        lg_reg   <= lg_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        opened_next = opened_reg;
        k_next      = k_reg;
        base_next   = base_reg;
        q_next      = q_reg;
        size_next   = size_reg;
        lg_next     = lg_reg;
        res_next    = res_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = k_reg;
        wr_fill     = '0;
        wr_live     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_FREE)
                    begin
                        q_next     = ADDR_W'(quot_prod >> SH);
                        state_next = S_FREE_RD;
                    end
                    else
                    begin
                        size_next = in_size;
                        lg_next   = in_lg;
                        base_next = '0;
                        k_next    = '0;
                        if (too_big)
                        begin
                            res_next   = '{block_address: '0, status: ST_NO_SPACE};
                            state_next = S_PUSH;
                        end
                        else if (opened_reg == '0)
                        begin
                            // Nothing open yet: open the first arena straight away.
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = '0;
                            wr_fill     = FW'(in_size);
                            wr_live     = LIVE_W'(1);
                            opened_next = CW'(1);
                            res_next    = '{block_address: '0, status: ST_OK};
                            state_next  = S_PUSH;
                        end
                        else
                        begin
                            mem_rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Data for arena k is here; fetch arena k+1 in case it is needed.
                mem_rd_addr = k_reg + AW'(1);
                if (fits)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = k_reg;
                    wr_fill     = FW'(need);
                    wr_live     = live_d + LIVE_W'(1);
                    res_next    = '{block_address: base_reg + ADDR_W'(start), status: ST_OK};
                    state_next  = S_PUSH;
                end
                else if (last_arena)
                begin
                    if (opened_reg < CW'(NUM_ARENAS))
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = opened_reg[AW-1:0];
                        wr_fill     = FW'(size_reg);
                        wr_live     = LIVE_W'(1);
                        opened_next = opened_reg + CW'(1);
                        res_next    = '{block_address: base_reg + ADDR_W'(ARENA_SIZE),
                                        status: ST_OK};
                    end
                    else
                    begin
                        res_next = '{block_address: '0, status: ST_NO_SPACE};
                    end
                    state_next = S_PUSH;
                end
                else
                begin
                    k_next    = k_reg + AW'(1);
                    base_next = base_reg + ADDR_W'(ARENA_SIZE);
                end
            end

            S_FREE_RD:
            begin
                mem_rd_addr = q_reg[AW-1:0];
                state_next  = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                if (!q_in_range || (live_d == '0))
                begin
                    res_next = '{block_address: '0, status: ST_BAD_FREE};
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = q_reg[AW-1:0];
                    wr_live     = live_d - LIVE_W'(1);
                    wr_fill     = (live_d == LIVE_W'(1)) ? '0 : fill_d;
                    res_next    = '{block_address: '0, status: ST_OK};
                end
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_opened_bound: assert property (@(posedge clk) disable iff (!rst_n)
        opened_reg <= CW'(NUM_ARENAS))
        else $error("more arenas opened than exist");

    a_opened_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(opened_reg) |-> opened_reg == $past(opened_reg) + CW'(1))
        else $error("opened arena count moved by other than one");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_IDLE || state_reg == S_SCAN ||
                       state_reg == S_FREE_CHK))
        else $error("arena memory written outside an update step");

    a_bad_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.status == ST_BAD_FREE) |-> res_reg.block_address == '0)
        else $error("rejected free carries a non-zero address");
`endif

endmodule

>>> src/multi_arena_bump_allocator.sv
// Top level of the multi-arena bump allocator: stream ports, output register and sequencer.
//
//   Channel  Direction  Carries
//   s_*      in         one request per transaction: tuser = mode, tdata = size, alignment, address
//   m_*      out        one result per request: tdata = block address, tuser = status
//
// An allocate goes straight to its result when no arena is open or the request is too large, and
// otherwise scans the opened arenas first-fit, reading one arena entry per cycle from the arena
// memory. A free reads the arena entry, checks and updates it, then presents its result.
// Reset clears the opened-arena count and the sequencer; arena entries are always written when
// an arena is opened, so the memory needs no clearing pass and the block is ready at once.
// A finished result sits in the output register while the next request is worked on; only a
// second result finding that register still full holds the sequencer back.
module multi_arena_bump_allocator
    import mab_pkg::*;
#(
    parameter int NUM_ARENAS = NUM_ARENAS_DEF,
    parameter int ARENA_SIZE = ARENA_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Bits from lowest: req_size[12:0], align_log2[16:13], free_address[31:17].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Bit 0: mode (0 allocate, 1 free).
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Bits from lowest: block_address[14:0], then one zero bit.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Bits from lowest: status[1:0] (0 ok, 1 no space, 2 bad free).
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int AW = (NUM_ARENAS > 1) ? $clog2(NUM_ARENAS) : 1;
    localparam int FW = $clog2(ARENA_SIZE + 1);
    localparam int DW = FW + LIVE_W;

    logic          res_valid, res_ready;
    res_t          res;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] rd_data, wr_data;
    logic          wr_en;

    logic          m_tvalid_reg, m_tvalid_next;
    res_t          out_reg, out_next;

    // Each arena's entry holds its fill level above its live object count.
    mab_arena_ram #(
        .DEPTH (NUM_ARENAS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // The sequencer finishes each request, writes back its entry, then waits for the output slot,
    // so a new request never reads an entry that is still being written.
    mab_seq #(
        .NUM_ARENAS (NUM_ARENAS),
        .ARENA_SIZE (ARENA_SIZE),
        .AW         (AW),
        .FW         (FW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser[0]),
        .in_size     (s_tdata[SIZE_W-1:0]),
        .in_lg       (s_tdata[SIZE_W+LG_W-1:SIZE_W]),
        .in_faddr    (s_tdata[SIZE_W+LG_W+ADDR_W-1:SIZE_W+LG_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_addr (rd_addr),
        .mem_rd_data (rd_data),
        .mem_wr_en   (wr_en),
        .mem_wr_addr (wr_addr),
        .mem_wr_data (wr_data)
    );

    // Output register: takes a result whenever it is empty or being emptied this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg.block_address);
    assign m_tuser  = out_reg.status;

endmodule
